// ===== rtl/cbor_pkg.sv =====
// Package for the CAN bus-off recovery supervisor: types, state codes, constants.
package cbor_pkg;

  localparam int unsigned TimerW = 16;
  localparam int unsigned CountW = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [TimerW-1:0] TimerMax = 16'hFFFF;
  localparam logic [TimerW-1:0] WatchTicks = 16'd100;

  // Recovery states
  localparam logic [1:0] StCheck = 2'd0;
  localparam logic [1:0] StFast  = 2'd1;
  localparam logic [1:0] StSlow  = 2'd2;
  localparam logic [1:0] StWatch = 2'd3;

  // Item function codes
  localparam logic FuncTick = 1'b0;
  localparam logic FuncPoll = 1'b1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegFastWait   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegSlowWait   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegFastTries  = 2'd2;
  localparam logic [CfgIdxW-1:0] RegHoldoff    = 2'd3;

  typedef struct packed {
    logic [TimerW-1:0] fast_wait_ticks;
    logic [TimerW-1:0] slow_wait_ticks;
    logic [CountW-1:0] fast_attempts;
    logic [TimerW-1:0] startup_holdoff;
  } cbor_cfg_t;

  typedef struct packed {
    logic              func;
    logic              bus_off_flag;
    logic [CountW-1:0] bus_off_count;
  } cbor_item_t;

  typedef struct packed {
    logic [1:0]        off_state;
    logic [TimerW-1:0] off_timer;
    logic [TimerW-1:0] startup_timer;
  } cbor_state_t;

  typedef struct packed {
    logic [1:0] recovery_state;
    logic       in_bus_off;
    logic       go_off_bus;
    logic       reinit_controller;
    logic       recovered;
  } cbor_res_t;

endpackage

// ===== rtl/cbor_step.sv =====
// Next-state and result logic for one tick or poll item.
module cbor_step (
  input  cbor_pkg::cbor_cfg_t   cfg_i,
  input  cbor_pkg::cbor_state_t cur_i,
  input  cbor_pkg::cbor_item_t  item_i,
  output cbor_pkg::cbor_state_t nxt_o,
  output cbor_pkg::cbor_res_t   res_o
);
  import cbor_pkg::*;

  logic go_off, reinit, recov;

  always_comb begin
    nxt_o  = cur_i;
    go_off = 1'b0;
    reinit = 1'b0;
    recov  = 1'b0;
    if (item_i.func == FuncTick) begin
      // both counters saturate
      if (cur_i.startup_timer != TimerMax) begin
        nxt_o.startup_timer = cur_i.startup_timer + TimerW'(1);
      end
      if (cur_i.off_timer != TimerMax) begin
        nxt_o.off_timer = cur_i.off_timer + TimerW'(1);
      end
    end else begin
      case (cur_i.off_state)
        StCheck: begin
          if (item_i.bus_off_flag && (cur_i.startup_timer > cfg_i.startup_holdoff)) begin
            go_off = 1'b1;
            nxt_o.off_timer = '0;
            nxt_o.off_state = (cfg_i.fast_attempts != '0) ? StFast : StSlow;
          end
        end
        StFast: begin
          if (cur_i.off_timer >= cfg_i.fast_wait_ticks) begin
            reinit = 1'b1;
            nxt_o.off_timer = '0;
            nxt_o.off_state = StWatch;
          end
        end
        StSlow: begin
          if (cur_i.off_timer >= cfg_i.slow_wait_ticks) begin
            reinit = 1'b1;
            nxt_o.off_timer = '0;
            nxt_o.off_state = StWatch;
          end
        end
        default: begin
          // new bus-off beats end of watch
          if (item_i.bus_off_flag) begin
            go_off = 1'b1;
            nxt_o.off_timer = '0;
            nxt_o.off_state = (item_i.bus_off_count <= cfg_i.fast_attempts) ? StFast : StSlow;
          end else if (cur_i.off_timer >= WatchTicks) begin
            recov = 1'b1;
            nxt_o.off_state = StCheck;
          end
        end
      endcase
    end
  end

  assign res_o.recovery_state    = nxt_o.off_state;
  assign res_o.in_bus_off        = (nxt_o.off_state != StCheck);
  assign res_o.go_off_bus        = go_off;
  assign res_o.reinit_controller = reinit;
  assign res_o.recovered         = recov;

endmodule

// ===== rtl/can_bus_off_recovery.sv =====
// Top level of the CAN bus-off recovery supervisor.
// Takes one item per clock while not stalled: a tick (func 0) advances the
// start-up and bus-off timers, both saturating at 65535; a poll (func 1) runs
// the four-state recovery machine (check, fast wait, slow wait, recovery watch)
// and may raise one of the go_off_bus, reinit_controller or recovered pulses
// in its result. Every item yields exactly one result item. An item passes an
// input register, then a single layer of compare/increment logic that also
// updates the machine state, then a result register; out_valid_o rises once
// the item is in the result register, and throughput is one item per cycle
// while out_stall_i is low.
// The input side stalls only when both the input and the result register are
// full and the result is held. Registers are written through cfg_we_i /
// cfg_idx_i / cfg_data_i (0 fast wait, 1 slow wait, 2 fast attempts using the
// low 8 bits, 3 start-up hold-off) and should only change while idle.
module can_bus_off_recovery (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // item input
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           func_i,
  input  logic                           bus_off_flag_i,
  input  logic [7:0]                     bus_off_count_i,
  // result output
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [1:0]                     recovery_state_o,
  output logic                           in_bus_off_o,
  output logic                           go_off_bus_o,
  output logic                           reinit_controller_o,
  output logic                           recovered_o,
  // register writes
  input  logic                           cfg_we_i,
  input  logic [cbor_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [cbor_pkg::CfgDataW-1:0]  cfg_data_i
);
  import cbor_pkg::*;

  cbor_cfg_t   cfg_q, cfg_d;
  cbor_state_t st_q, st_nxt;
  cbor_item_t  item_q;
  cbor_res_t   res_q, res_nxt;
  logic        in_vld_q, out_vld_q;
  logic        advance, in_take;

  // result register free, or being emptied this cycle
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // register file
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        RegFastWait:  cfg_d.fast_wait_ticks = cfg_data_i;
        RegSlowWait:  cfg_d.slow_wait_ticks = cfg_data_i;
        RegFastTries: cfg_d.fast_attempts   = cfg_data_i[CountW-1:0];
        RegHoldoff:   cfg_d.startup_holdoff = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fast_wait_ticks <= 16'd10;
      cfg_q.slow_wait_ticks <= 16'd100;
      cfg_q.fast_attempts   <= 8'd5;
      cfg_q.startup_holdoff <= 16'd50;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_take) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.func          <= func_i;
      item_q.bus_off_flag  <= bus_off_flag_i;
      item_q.bus_off_count <= bus_off_count_i;
    end
  end

  cbor_step u_step (
    .cfg_i  (cfg_q),
    .cur_i  (st_q),
    .item_i (item_q),
    .nxt_o  (st_nxt),
    .res_o  (res_nxt)
  );

  // machine state moves once per item, as the item enters the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.off_state     <= StCheck;
      st_q.off_timer     <= '0;
      st_q.startup_timer <= '0;
    end else if (advance) begin
      st_q <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_nxt;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign recovery_state_o    = res_q.recovery_state;
  assign in_bus_off_o        = res_q.in_bus_off;
  assign go_off_bus_o        = res_q.go_off_bus;
  assign reinit_controller_o = res_q.reinit_controller;
  assign recovered_o         = res_q.recovered;

endmodule

// ===== rtl/cbor_chk.sv =====
// Port-level checker for the CAN bus-off recovery supervisor, with its bind.
module cbor_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] recovery_state_o,
  input logic       in_bus_off_o,
  input logic       go_off_bus_o,
  input logic       reinit_controller_o,
  input logic       recovered_o
);
  import cbor_pkg::*;

  // a held result keeps its state field
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(recovery_state_o))
    else $error("held result changed");

  a_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (in_bus_off_o == (recovery_state_o != StCheck)))
    else $error("in_bus_off disagrees with state");

  a_onepulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> $onehot0({go_off_bus_o, reinit_controller_o, recovered_o}))
    else $error("more than one action pulse");

  a_gooff: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && go_off_bus_o |-> (recovery_state_o == StFast || recovery_state_o == StSlow))
    else $error("go_off_bus without wait state");

  a_reinit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && reinit_controller_o |-> recovery_state_o == StWatch)
    else $error("reinit without watch state");

endmodule

bind can_bus_off_recovery cbor_chk u_cbor_chk (
  .clk_i               (clk_i),
  .rst_ni              (rst_ni),
  .out_valid_o         (out_valid_o),
  .out_stall_i         (out_stall_i),
  .recovery_state_o    (recovery_state_o),
  .in_bus_off_o        (in_bus_off_o),
  .go_off_bus_o        (go_off_bus_o),
  .reinit_controller_o (reinit_controller_o),
  .recovered_o         (recovered_o)
);

// ===== test/cbor_checker.sv =====
// Checker for the bus-off recovery supervisor: predicts each result item and compares it.
`timescale 1ns / 100ps

module cbor_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          func_i,
  input  logic                          bus_off_flag_i,
  input  logic [cbor_pkg::CountW-1:0]   bus_off_count_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [1:0]                    recovery_state_i,
  input  logic                          in_bus_off_i,
  input  logic                          go_off_bus_i,
  input  logic                          reinit_controller_i,
  input  logic                          recovered_i,
  input  logic                          cfg_we_i,
  input  logic [cbor_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [cbor_pkg::CfgDataW-1:0] cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import cbor_pkg::*;

  // Shadow copy of the supervisor
  cbor_cfg_t         regs;
  logic [1:0]        sv_state;
  logic [TimerW-1:0] off_ticks;
  logic [TimerW-1:0] uptime_ticks;

  cbor_res_t         due_actions[$];
  cbor_res_t         want;
  cbor_item_t        item;
  int                fails = 0;
  int                pending = 0;

  assign fail_count_o = fails;
  assign pending_o    = pending;

  function automatic logic [TimerW-1:0] bump(input logic [TimerW-1:0] v);
    return (v == TimerMax) ? v : v + TimerW'(1);
  endfunction

  // Applies one item to the shadow state, returns the result it causes
  function automatic cbor_res_t advance_supervisor(input cbor_item_t it);
    cbor_res_t r;
    r = '0;
    if (it.func == FuncTick) begin
      uptime_ticks = bump(uptime_ticks);
      off_ticks    = bump(off_ticks);
    end else begin
      case (sv_state)
        StCheck: begin
          if (uptime_ticks > regs.startup_holdoff && it.bus_off_flag) begin
            r.go_off_bus = 1'b1;
            off_ticks    = '0;
            sv_state     = (regs.fast_attempts != '0) ? StFast : StSlow;
          end
        end
        StFast: begin
          if (off_ticks >= regs.fast_wait_ticks) begin
            r.reinit_controller = 1'b1;
            off_ticks           = '0;
            sv_state            = StWatch;
          end
        end
        StSlow: begin
          if (off_ticks >= regs.slow_wait_ticks) begin
            r.reinit_controller = 1'b1;
            off_ticks           = '0;
            sv_state            = StWatch;
          end
        end
        default: begin
          // a new bus-off wins over the end of the watch
          if (it.bus_off_flag) begin
            r.go_off_bus = 1'b1;
            off_ticks    = '0;
            sv_state     = (it.bus_off_count <= regs.fast_attempts) ? StFast : StSlow;
          end else if (off_ticks >= WatchTicks) begin
            r.recovered = 1'b1;
            sv_state    = StCheck;
          end
        end
      endcase
    end
    r.recovery_state = sv_state;
    r.in_bus_off     = (sv_state != StCheck);
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v, got_v);
    if (exp_v != got_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, got_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      regs.fast_wait_ticks = 16'd10;
      regs.slow_wait_ticks = 16'd100;
      regs.fast_attempts   = 8'd5;
      regs.startup_holdoff = 16'd50;
      sv_state             = StCheck;
      off_ticks            = '0;
      uptime_ticks         = '0;
      due_actions.delete();
      pending              = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_actions.size() == 0) begin
          $error("unexpected result item: recovery_state %0d", recovery_state_i);
          fails++;
        end else begin
          want = due_actions.pop_front();
          check_field("recovery_state", want.recovery_state, recovery_state_i);
          check_field("in_bus_off", want.in_bus_off, in_bus_off_i);
          check_field("go_off_bus", want.go_off_bus, go_off_bus_i);
          check_field("reinit_controller", want.reinit_controller, reinit_controller_i);
          check_field("recovered", want.recovered, recovered_i);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        item.func          = func_i;
        item.bus_off_flag  = bus_off_flag_i;
        item.bus_off_count = bus_off_count_i;
        due_actions.push_back(advance_supervisor(item));
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          RegFastWait:  regs.fast_wait_ticks = cfg_data_i;
          RegSlowWait:  regs.slow_wait_ticks = cfg_data_i;
          RegFastTries: regs.fast_attempts   = cfg_data_i[CountW-1:0];
          RegHoldoff:   regs.startup_holdoff = cfg_data_i;
          default: ;
        endcase
      end
      pending = due_actions.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
// Testbench top for the bus-off recovery supervisor: stimulus, receiver, watchdog, verdict.
`timescale 1ns / 100ps

module tb_top;
  import cbor_pkg::*;

  localparam int HoldCycles = 400;   // long receiver hold-off
  localparam int QuietLimit = 2000;  // watchdog: cycles with no item moving
  localparam int PhaseItems = 180;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                func_i = FuncTick;
  logic                bus_off_flag_i = 1'b0;
  logic [7:0]          bus_off_count_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          recovery_state_o;
  logic                in_bus_off_o;
  logic                go_off_bus_o;
  logic                reinit_controller_o;
  logic                recovered_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  int                  fail_count;
  int                  pending;

  // Idle knobs, set per phase by the stimulus
  int                  send_idle_pct = 0;
  int                  recv_stall_pct = 0;
  bit                  hold_req = 1'b0;
  logic [7:0]          cur_attempts = 8'd5;
  int                  quiet_cycles = 0;

  always #6 clk_i = ~clk_i;

  can_bus_off_recovery dut (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .func_i, .bus_off_flag_i, .bus_off_count_i,
    .out_valid_o, .out_stall_i, .recovery_state_o, .in_bus_off_o,
    .go_off_bus_o, .reinit_controller_o, .recovered_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  cbor_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_i(in_stall_o), .func_i, .bus_off_flag_i, .bus_off_count_i,
    .out_valid_i(out_valid_o), .out_stall_i,
    .recovery_state_i(recovery_state_o), .in_bus_off_i(in_bus_off_o),
    .go_off_bus_i(go_off_bus_o), .reinit_controller_i(reinit_controller_o),
    .recovered_i(recovered_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Offer one item, with a random gap first; returns at the falling edge
  // after the item was taken. Called at a falling edge.
  task automatic offer(input logic f, input logic fl, input logic [7:0] c);
    logic taken;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i      <= 1'b0;
      func_i          <= 1'($urandom);
      bus_off_flag_i  <= 1'($urandom);
      bus_off_count_i <= 8'($urandom);
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= f;
    bus_off_flag_i  <= fl;
    bus_off_count_i <= c;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !in_stall_o;
      @(negedge clk_i);
    end
  endtask

  // Drop valid and wait until every expected result item is back,
  // then let the two-stage pipe go quiet.
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Write all four registers back to back; only while idle.
  task automatic load_setting(input logic [15:0] fast_w, input logic [15:0] slow_w,
                              input logic [7:0] tries, input logic [15:0] holdoff);
    logic [7:0] junk;
    junk = 8'($urandom);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegFastWait;
    cfg_data_i <= fast_w;
    @(negedge clk_i);
    cfg_idx_i  <= RegSlowWait;
    cfg_data_i <= slow_w;
    @(negedge clk_i);
    // upper byte is don't-care for this register
    cfg_idx_i  <= RegFastTries;
    cfg_data_i <= {junk, tries};
    @(negedge clk_i);
    cfg_idx_i  <= RegHoldoff;
    cfg_data_i <= holdoff;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    cur_attempts = tries;
  endtask

  // Counts near the fast/slow boundary are the interesting ones
  function automatic logic [7:0] pick_count();
    case ($urandom_range(0, 4))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return cur_attempts;
      3:       return cur_attempts + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, or one long hold-off when asked
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(negedge clk_i);
      end
      out_stall_i <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: nothing moving on either channel for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    int n;
    int blen;
    int scen;
    int tick_pct;
    int flag_pct;
    logic f;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ---- directed part ----
    // short waits and a hold-off of two ticks so the whole machine fits
    load_setting(16'd1, 16'd2, 8'd1, 16'd2);
    offer(FuncPoll, 1'b1, 8'd0);    // hold-off: flag ignored at uptime 0
    offer(FuncTick, 1'b1, 8'd255);  // ticks carry flag/count junk
    offer(FuncTick, 1'b0, 8'd0);
    offer(FuncPoll, 1'b1, 8'd0);    // uptime == hold-off: still ignored
    offer(FuncTick, 1'b0, 8'd0);
    offer(FuncPoll, 1'b0, 8'd255);  // no flag: stays in check
    offer(FuncPoll, 1'b1, 8'd255);  // past hold-off: off bus, fast wait
    offer(FuncPoll, 1'b1, 8'd0);    // fast wait not yet done
    offer(FuncTick, 1'b0, 8'd0);    // tick while off bus: no pulses
    offer(FuncPoll, 1'b0, 8'd0);    // fast wait done: reinit, watch
    offer(FuncPoll, 1'b1, 8'd1);    // new bus-off, count == attempts: fast
    offer(FuncTick, 1'b0, 8'd0);
    offer(FuncPoll, 1'b0, 8'd0);    // reinit
    offer(FuncPoll, 1'b1, 8'd255);  // new bus-off, count above attempts: slow
    offer(FuncTick, 1'b0, 8'd0);
    offer(FuncPoll, 1'b0, 8'd0);    // slow wait not yet done
    offer(FuncTick, 1'b0, 8'd0);
    offer(FuncPoll, 1'b0, 8'd0);    // slow wait done: reinit, watch
    offer(FuncPoll, 1'b0, 8'd0);    // watch time not over
    settle();
    // zero attempts and zero waits
    load_setting(16'd0, 16'd0, 8'd0, 16'd0);
    offer(FuncPoll, 1'b1, 8'd0);    // in watch, count 0 <= 0: still fast
    offer(FuncPoll, 1'b0, 8'd0);    // zero wait ends on first poll
    offer(FuncPoll, 1'b1, 8'd1);    // count 1 > 0: slow
    offer(FuncPoll, 1'b0, 8'd0);    // zero slow wait
    settle();

    // ---- random phases ----
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: load_setting(16'd3, 16'd8, 8'd2, 16'd0);
        1: load_setting(16'd0, 16'd0, 8'd0, 16'd0);
        2: load_setting(16'd0, 16'd5, 8'd255, 16'd10);
        3: load_setting(16'd6, 16'd0, 8'd1, 16'd0);
        4: load_setting(16'd2, 16'd3, 8'd3, 16'd0);
        default: load_setting(16'($urandom_range(0, 12)), 16'($urandom_range(0, 30)),
                              ($urandom_range(0, 3) == 0) ? 8'($urandom) :
                                                            8'($urandom_range(0, 6)),
                              16'($urandom_range(0, 1500)));
      endcase
      // idle mix cycles through: none, sender, receiver, both lightly
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 67; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 67; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      n = 0;
      while (n < PhaseItems) begin
        // quiet bursts let a full recovery and watch run out;
        // storms keep knocking the node off the bus
        scen = $urandom_range(0, 2);
        case (scen)
          0: begin tick_pct = 80; flag_pct = 2;  blen = $urandom_range(40, 160); end
          1: begin tick_pct = 40; flag_pct = 60; blen = $urandom_range(5, 40);   end
          default: begin tick_pct = 65; flag_pct = 20; blen = $urandom_range(5, 40); end
        endcase
        for (int k = 0; k < blen && n < PhaseItems; k++) begin
          f = ($urandom_range(0, 99) < tick_pct) ? FuncTick : FuncPoll;
          offer(f, ($urandom_range(0, 99) < flag_pct), pick_count());
          n++;
          // long receiver hold while the sender keeps pushing
          if (phase == 0 && n == 100) hold_req = 1'b1;
        end
      end
      settle();
    end

    // ---- extreme settings ----
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // back to check from wherever the random part left the machine
    load_setting(16'd0, 16'd0, 8'd255, 16'd0);
    offer(FuncPoll, 1'b0, 8'd0);           // a wait state ends at once
    repeat (101) offer(FuncTick, 1'($urandom), 8'($urandom));
    offer(FuncPoll, 1'b0, 8'd0);           // watch over: recovered
    settle();
    load_setting(16'hFFFF, 16'hFFFF, 8'd255, 16'hFFFF);
    offer(FuncPoll, 1'b1, 8'd0);           // uptime below the largest hold-off: ignored
    settle();
    load_setting(16'hFFFF, 16'hFFFF, 8'd255, 16'd0);
    offer(FuncPoll, 1'b1, 8'($urandom));   // off bus, fast wait
    repeat (20) offer(FuncTick, 1'b0, 8'd0);
    offer(FuncPoll, 1'b0, 8'd0);           // longest wait not over
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
